FILE: hdl/hex_text_line_decoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hex text line decoder
// Clocked concurrent assertions that compile away under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef HEX_TEXT_LINE_DECODER_DEFINES_SVH
`define HEX_TEXT_LINE_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked while out of reset
`define HTLD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("htld assertion failed");
// checked on every edge, reset included
`define HTLD_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("htld assertion failed");
`else
`define HTLD_ASSERT(lbl, prop)
`define HTLD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: hdl/htld_pkg.sv
// ----------------------------------------------------------------------------
// htld_pkg
// Shared constants and types of the hex text line decoder.
// ----------------------------------------------------------------------------
package htld_pkg;

	localparam int HEX_CHARS = 16;
	localparam int CNT_W     = 5;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_SHORT   = 3'd1;
	localparam logic [2:0] ST_GARBAGE = 3'd2;
	localparam logic [2:0] ST_BADHEX  = 3'd3;
	localparam logic [2:0] ST_EOI     = 3'd4;

	localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] data_word;
		logic [31:0] line_number;
		logic        last;
	} res_t;

	// results produced by one item, in order; push_cnt of them are real
	typedef struct packed {
		logic [1:0] push_cnt;
		res_t       first;
		res_t       second;
	} parse_out_t;

endpackage

FILE: hdl/htld_char_if.sv
// ----------------------------------------------------------------------------
// htld_char_if
// Character channel: one text byte or an end-of-input mark per transfer.
// ----------------------------------------------------------------------------
interface htld_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_input;

	modport source (output valid, output char_code, output end_of_input, input ready);
	modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

FILE: hdl/htld_result_if.sv
// ----------------------------------------------------------------------------
// htld_result_if
// Result channel: one line outcome per transfer.
// ----------------------------------------------------------------------------
interface htld_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] data_word;
	logic [31:0] line_number;
	logic        last;

	modport source (output valid, output status, output data_word, output line_number,
		output last, input ready);
	modport sink (input valid, input status, input data_word, input line_number,
		input last, output ready);
endinterface

FILE: hdl/hex_text_line_decoder.sv
// ----------------------------------------------------------------------------
// hex_text_line_decoder
// Parses a text stream of hex lines into 64-bit words with line status.
// ----------------------------------------------------------------------------
// Usage:
//   chars   : one byte per transfer; end_of_input = 1 flushes the pending
//             line and closes the stream (char_code is then ignored).
//   results : one line outcome per transfer; last marks the final result
//             caused by one input byte.
//   A byte is registered on transfer and parsed from that register while
//   the result queue holds at most two results; its results enter a
//   4-entry result queue. Throughput is one byte per cycle while the
//   queue has that room. An end-of-input that flushes a line gives two
//   results, which the result queue drains one per transfer.
//   The input stage takes a byte while its register is empty or the
//   queue holds at most two results, so a stalled receiver fills the
//   queue and then chars.ready drops; nothing is lost.
//   Reset clears the line state, the line counter and the queue. After
//   end_of_input the parser is back in its reset state and line numbers
//   start from one again.
// ----------------------------------------------------------------------------
`include "hex_text_line_decoder_defines.svh"

module hex_text_line_decoder (
	input  logic          clk,
	input  logic          arst_n,
	htld_char_if.sink     chars,
	htld_result_if.source results
);
	import htld_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;
	logic       adv;
	logic       in_xfer, out_xfer;

	parse_out_t pout;

	res_t       mem_q [4];
	logic [1:0] rd_ptr_q, wr_ptr_q;
	logic [2:0] count_q;
	logic [1:0] push;

	assign adv         = valid_s1 && (count_q <= 3'd2);
	assign chars.ready = !valid_s1 || adv;
	assign in_xfer     = chars.valid && chars.ready;
	assign out_xfer    = results.valid && results.ready;
	assign push        = adv ? pout.push_cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_s1 <= chars.char_code;
			eoi_s1  <= chars.end_of_input;
		end
	end

	htld_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.char_code    (char_s1),
		.end_of_input (eoi_s1),
		.pout         (pout)
	);

	// result queue
	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			mem_q[wr_ptr_q] <= pout.first;
		end
		if (push == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= pout.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push;
			rd_ptr_q <= rd_ptr_q + {1'b0, out_xfer};
			count_q  <= count_q + {1'b0, push} - {2'b00, out_xfer};
		end
	end

	assign results.valid       = (count_q != 3'd0);
	assign results.status      = mem_q[rd_ptr_q].status;
	assign results.data_word   = mem_q[rd_ptr_q].data_word;
	assign results.line_number = mem_q[rd_ptr_q].line_number;
	assign results.last        = mem_q[rd_ptr_q].last;

	`HTLD_ASSERT(a_queue_bound, count_q <= 3'd4)
	`HTLD_ASSERT(a_push_room, (push != 2'd0) |-> (count_q <= 3'd2))
	`HTLD_ASSERT(a_eoi_result, (adv && eoi_s1) |=> (count_q != 3'd0))
	`HTLD_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (count_q == 3'd0 && !valid_s1))

endmodule

FILE: hdl/htld_parser.sv
// ----------------------------------------------------------------------------
// htld_parser
// Line state machine: consumes one registered character per advance and
// returns the results it causes.
// ----------------------------------------------------------------------------
module htld_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [7:0]          char_code,
	input  logic                end_of_input,
	output htld_pkg::parse_out_t pout
);
	import htld_pkg::*;

	localparam logic [1:0] PH_SKIP    = 2'd0;
	localparam logic [1:0] PH_COLLECT = 2'd1;
	localparam logic [1:0] PH_TRAIL   = 2'd2;
	localparam logic [1:0] PH_DISCARD = 2'd3;

	logic [1:0]       phase_q, phase_n;
	logic [CNT_W-1:0] taken_q, taken_n;
	logic [63:0]      word_q, word_n;
	logic             derr_q, derr_n;
	logic [31:0]      line_q, line_n;

	logic [31:0]      cur_line, inc_line;
	logic             ws, lf, stop, hash;
	logic [4:0]       nib;
	logic [2:0]       good;
	logic [CNT_W-1:0] tk_base;
	logic [63:0]      wd_base;
	logic             de_base;
	logic [CNT_W-1:0] tk_next;

	// bit 4 flags a non-hex character
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		logic [4:0] n;
		n = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) n = {1'b0, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) n = {1'b0, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) n = {1'b0, 4'(c - 8'h37)};
		return n;
	endfunction

	function automatic res_t mk_res(input logic [2:0] st, input logic [63:0] w,
		input logic [31:0] ln, input logic lst);
		res_t r;
		r.status      = st;
		r.data_word   = (st == ST_OK) ? w : 64'd0;
		r.line_number = ln;
		r.last        = lst;
		return r;
	endfunction

	always_comb begin
		ws       = (char_code == 8'h20) || (char_code == 8'h09);
		lf       = (char_code == 8'h0A);
		stop     = (char_code == 8'h0D) || (char_code == 8'h00);
		hash     = (char_code == 8'h23);
		nib      = nibble_of(char_code);
		cur_line = (line_q == LINE_MAX) ? line_q : line_q + 32'd1;
		inc_line = cur_line;
		good     = derr_q ? ST_BADHEX : ST_OK;

		// a new line starts from a clean accumulator
		if (phase_q == PH_SKIP) begin
			tk_base = '0;
			wd_base = '0;
			de_base = 1'b0;
		end else begin
			tk_base = taken_q;
			wd_base = word_q;
			de_base = derr_q;
		end
		tk_next = tk_base + CNT_W'(1);

		phase_n = phase_q;
		taken_n = taken_q;
		word_n  = word_q;
		derr_n  = derr_q;
		line_n  = line_q;

		pout.push_cnt = 2'd0;
		pout.first    = mk_res(ST_EOI, 64'd0, line_q, 1'b1);
		pout.second   = mk_res(ST_EOI, 64'd0, line_q, 1'b1);

		if (end_of_input) begin
			unique case (phase_q)
				PH_COLLECT: begin
					pout.push_cnt = 2'd2;
					pout.first    = mk_res(ST_SHORT, 64'd0, cur_line, 1'b0);
					pout.second   = mk_res(ST_EOI, 64'd0, cur_line, 1'b1);
				end
				PH_TRAIL: begin
					pout.push_cnt = 2'd2;
					pout.first    = mk_res(good, word_q, cur_line, 1'b0);
					pout.second   = mk_res(ST_EOI, 64'd0, cur_line, 1'b1);
				end
				default: begin
					pout.push_cnt = 2'd1;
				end
			endcase
			phase_n = PH_SKIP;
			taken_n = '0;
			word_n  = '0;
			derr_n  = 1'b0;
			line_n  = '0;
		end else begin
			unique case (phase_q)
				PH_SKIP, PH_COLLECT: begin
					if (phase_q == PH_SKIP && ws) begin
						// leading whitespace
					end else if (phase_q == PH_SKIP && lf) begin
						line_n = inc_line;
					end else if (phase_q == PH_SKIP && (stop || hash)) begin
						phase_n = PH_DISCARD;
					end else if (phase_q == PH_COLLECT && (lf || stop)) begin
						pout.push_cnt = 2'd1;
						pout.first    = mk_res(ST_SHORT, 64'd0, cur_line, 1'b1);
						if (lf) begin
							line_n  = inc_line;
							phase_n = PH_SKIP;
						end else begin
							phase_n = PH_DISCARD;
						end
					end else begin
						word_n  = {wd_base[59:0], nib[4] ? 4'd0 : nib[3:0]};
						derr_n  = de_base | nib[4];
						taken_n = tk_next;
						phase_n = (tk_next >= CNT_W'(HEX_CHARS)) ? PH_TRAIL : PH_COLLECT;
					end
				end
				PH_TRAIL: begin
					if (!ws) begin
						pout.push_cnt = 2'd1;
						if (lf || stop || hash) begin
							pout.first = mk_res(good, word_q, cur_line, 1'b1);
						end else begin
							pout.first = mk_res(ST_GARBAGE, 64'd0, cur_line, 1'b1);
						end
						if (lf) begin
							line_n  = inc_line;
							phase_n = PH_SKIP;
						end else begin
							phase_n = PH_DISCARD;
						end
					end
				end
				default: begin
					if (lf) begin
						line_n  = inc_line;
						phase_n = PH_SKIP;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			taken_q <= '0;
			word_q  <= '0;
			derr_q  <= 1'b0;
			line_q  <= '0;
		end else if (adv) begin
			phase_q <= phase_n;
			taken_q <= taken_n;
			word_q  <= word_n;
			derr_q  <= derr_n;
			line_q  <= line_n;
		end
	end

endmodule

FILE: sim/tb_hex_text_line_decoder.sv
// ----------------------------------------------------------------------------
// tb_hex_text_line_decoder
// Self-checking bench for the hex text line decoder. Text bytes go in over
// the char channel with bursty timing; a line parser model in the bench works
// out the expected outcomes, and each result transfer is compared field by
// field against the oldest of them while the result side stalls on its own.
// ----------------------------------------------------------------------------
module tb_hex_text_line_decoder;
	import htld_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int END_CYCLES  = 8;
	localparam int RANDOM_BYTES = 1100;
	localparam int MAX_REPORTS = 40;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;

	localparam string HEX_SET = "0123456789abcdefABCDEF";

	typedef enum logic [1:0] {LN_SKIP, LN_COLLECT, LN_TRAIL, LN_DISCARD} line_phase_t;

	logic clk;
	logic arst_n;

	htld_char_if   chars_if();
	htld_result_if res_if();

	hex_text_line_decoder DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (res_if)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser model state
	line_phase_t line_phase;
	logic [4:0]  hex_taken;
	logic [63:0] nibble_acc;
	logic        bad_digit;
	logic [31:0] lines_done;

	res_t pending_outcomes[$];
	res_t step_outcomes[$];
	res_t want;
	logic [7:0] line_buf[$];

	int mismatches = 0;
	int bytes_sent = 0;
	int cycles = 0;
	int burst_left = 0;
	int seen_by_status[0:7];

	int rx_kind = 0;
	int rx_left = 0;
	int rx_tick = 0;
	int rx_period = 2;

	// ---------------- parser model ----------------

	function automatic int hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic void clear_parser();
		line_phase = LN_SKIP;
		hex_taken  = '0;
		nibble_acc = '0;
		bad_digit  = 1'b0;
		lines_done = '0;
	endfunction

	function automatic logic [31:0] line_in_progress();
		return (lines_done == LINE_MAX) ? LINE_MAX : lines_done + 32'd1;
	endfunction

	function automatic void bump_lines();
		if (lines_done != LINE_MAX) lines_done = lines_done + 32'd1;
	endfunction

	function automatic void add_outcome(input logic [2:0] status, input logic [31:0] line);
		res_t r;
		r.status      = status;
		r.data_word   = (status == ST_OK) ? nibble_acc : 64'd0;
		r.line_number = line;
		r.last        = 1'b0;
		step_outcomes.push_back(r);
	endfunction

	function automatic logic [2:0] field_outcome();
		return bad_digit ? ST_BADHEX : ST_OK;
	endfunction

	function automatic void take_hex(input logic [7:0] c);
		int v;
		v = hex_value(c);
		if (v < 0) begin
			bad_digit = 1'b1;
			v = 0;
		end
		nibble_acc = {nibble_acc[59:0], 4'(v)};
		hex_taken  = hex_taken + 5'd1;
		if (hex_taken >= HEX_CHARS) line_phase = LN_TRAIL;
	endfunction

	function automatic void predict_outcomes(input logic [7:0] c, input logic eoi);
		logic [31:0] total;
		logic ws, lf, stop;
		res_t r;
		ws   = (c == CH_SPACE) || (c == CH_TAB);
		lf   = (c == CH_LF);
		stop = (c == CH_CR) || (c == CH_NUL);
		if (eoi) begin
			total = lines_done;
			if (line_phase == LN_COLLECT) begin
				add_outcome(ST_SHORT, line_in_progress());
				total = line_in_progress();
			end else if (line_phase == LN_TRAIL) begin
				add_outcome(field_outcome(), line_in_progress());
				total = line_in_progress();
			end
			add_outcome(ST_EOI, total);
			clear_parser();
		end else begin
			case (line_phase)
				LN_SKIP: begin
					if (lf) begin
						bump_lines();
					end else if (stop || c == CH_HASH) begin
						line_phase = LN_DISCARD;
					end else if (!ws) begin
						line_phase = LN_COLLECT;
						hex_taken  = '0;
						nibble_acc = '0;
						bad_digit  = 1'b0;
						take_hex(c);
					end
				end
				LN_COLLECT: begin
					if (lf || stop) begin
						add_outcome(ST_SHORT, line_in_progress());
						if (lf) begin
							bump_lines();
							line_phase = LN_SKIP;
						end else begin
							line_phase = LN_DISCARD;
						end
					end else begin
						take_hex(c);
					end
				end
				LN_TRAIL: begin
					if (lf) begin
						add_outcome(field_outcome(), line_in_progress());
						bump_lines();
						line_phase = LN_SKIP;
					end else if (stop || c == CH_HASH) begin
						add_outcome(field_outcome(), line_in_progress());
						line_phase = LN_DISCARD;
					end else if (!ws) begin
						add_outcome(ST_GARBAGE, line_in_progress());
						line_phase = LN_DISCARD;
					end
				end
				default: begin
					if (lf) begin
						bump_lines();
						line_phase = LN_SKIP;
					end
				end
			endcase
		end
		while (step_outcomes.size() != 0) begin
			r = step_outcomes.pop_front();
			r.last = (step_outcomes.size() == 0);
			pending_outcomes.push_back(r);
		end
	endfunction

	// ---------------- channel drivers ----------------

	task automatic send_byte(input logic [7:0] c, input logic eoi);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 48);
			if (gap > 0) begin
				chars_if.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		chars_if.valid        = 1'b1;
		chars_if.char_code    = c;
		chars_if.end_of_input = eoi;
		do @(posedge clk); while (!chars_if.ready);
		predict_outcomes(c, eoi);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	task automatic send_eoi();
		send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_line_buf();
		while (line_buf.size() != 0) send_byte(line_buf.pop_front(), 1'b0);
	endtask

	// sender holds off until every outcome so far has been delivered
	task automatic wait_drained();
		@(negedge clk);
		chars_if.valid = 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	// result side stall patterns: always ready, coin flip, periodic, long stalls
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_kind   = $urandom_range(0, 3);
			rx_left   = $urandom_range(40, 300);
			rx_period = $urandom_range(2, 8);
			rx_tick   = 0;
		end
		rx_left--;
		rx_tick++;
		case (rx_kind)
			0: res_if.ready = 1'b1;
			1: res_if.ready = 1'($urandom_range(0, 1));
			2: res_if.ready = (rx_tick % rx_period) != 0;
			default: res_if.ready = (rx_tick % 16) >= 10;
		endcase
	end

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what, input logic [63:0] exp_val,
		input logic [63:0] got_val);
		if (mismatches < MAX_REPORTS)
			$display("MISMATCH %s: expected %0h, got %0h (cycle %0d)",
				what, exp_val, got_val, cycles);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result with no outcome pending", 64'd0, 64'(res_if.status));
			end else begin
				want = pending_outcomes.pop_front();
				if (res_if.status !== want.status)
					report_mismatch("status", 64'(want.status), 64'(res_if.status));
				if (res_if.data_word !== want.data_word)
					report_mismatch("data_word", want.data_word, res_if.data_word);
				if (res_if.line_number !== want.line_number)
					report_mismatch("line_number", 64'(want.line_number),
						64'(res_if.line_number));
				if (res_if.last !== want.last)
					report_mismatch("last", 64'(want.last), 64'(res_if.last));
				seen_by_status[want.status]++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outcomes pending", cycles,
				pending_outcomes.size());
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------- line builders ----------------

	function automatic logic [7:0] rand_hex();
		return HEX_SET[$urandom_range(0, HEX_SET.len() - 1)];
	endfunction

	// any byte that is not a hex digit and does not end the line
	function automatic logic [7:0] rand_non_hex();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (hex_value(c) >= 0 || c == CH_LF || c == CH_CR || c == CH_NUL);
		return c;
	endfunction

	function automatic void push_ws(input int n);
		for (int i = 0; i < n; i++) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endfunction

	function automatic void push_hex(input int n);
		for (int i = 0; i < n; i++) line_buf.push_back(rand_hex());
	endfunction

	function automatic void push_junk();
		logic [7:0] c;
		for (int i = $urandom_range(0, 6); i > 0; i--) begin
			do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
			line_buf.push_back(c);
		end
	endfunction

	// ---------------- tests ----------------

	task automatic test_good_lines();
		send_text("0000000000000000\n");
		send_text("FFFFFFFFFFFFFFFF\n");
		send_text(" \t0123456789abcdef  \t# note\n");
		send_text("FEDCBAfedcba9876\r tail\n");
		send_text("a5A5a5A5a5A5a5A5");
		send_byte(CH_NUL, 1'b0);
		send_text("x\n");
		wait_drained();
	endtask

	task automatic test_ignored_lines();
		send_text("\n \t \n# comment only\n\t#x\n\rzz\n");
		send_byte(CH_NUL, 1'b0);
		send_text("q\n");
		wait_drained();
	endtask

	task automatic test_short_lines();
		send_text("12ab\n");
		send_text("  7\r junk\n");
		send_text("0123456789abcde\n");
		send_text("abc");
		send_byte(CH_NUL, 1'b0);
		send_text("\n");
		wait_drained();
	endtask

	task automatic test_trailing_garbage();
		send_text("0123456789abcdefg\n");
		send_text("0123456789abcdef  x # c\n");
		send_text("0123456789abcdef0\n");
		wait_drained();
	endtask

	task automatic test_bad_digits();
		send_text("0123456789abcdeg\n");
		send_text("01#3456789abcdef\n");
		send_text("01 3456789abcdef\n");
		send_text("0123456");
		send_byte(8'hFF, 1'b0);
		send_text("89abcdef\n");
		// structural errors take precedence over a bad digit
		send_text("0g23\n");
		send_text("0g23456789abcdef z\n");
		wait_drained();
	endtask

	task automatic test_end_of_input();
		send_eoi();
		send_eoi();
		send_text("\n12");
		send_eoi();
		send_text("0123456789abcdef");
		send_eoi();
		send_text("\n\n0123456789abcdeZ \t");
		send_eoi();
		send_text("# open comment");
		send_eoi();
		wait_drained();
	endtask

	task automatic send_random_line();
		int kind, start;
		line_buf.delete();
		kind = $urandom_range(0, 99);
		push_ws(($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3));
		start = line_buf.size();
		if (kind < 10) begin
			case ($urandom_range(0, 3))
				0: ;
				1: line_buf.push_back(CH_HASH);
				2: line_buf.push_back(CH_CR);
				default: line_buf.push_back(CH_NUL);
			endcase
			push_junk();
			line_buf.push_back(CH_LF);
		end else if (kind < 18) begin
			push_hex($urandom_range(1, HEX_CHARS - 1));
			if ($urandom_range(0, 2) == 0)
				line_buf[$urandom_range(start, line_buf.size() - 1)] = rand_non_hex();
			case ($urandom_range(0, 2))
				0: ;
				1: line_buf.push_back(CH_CR);
				default: line_buf.push_back(CH_NUL);
			endcase
			push_junk();
			line_buf.push_back(CH_LF);
		end else if (kind < 26) begin
			for (int i = $urandom_range(1, 24); i > 0; i--)
				line_buf.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 33) begin
			// stream ends part way through a line
			push_hex($urandom_range(0, HEX_CHARS + 2));
			if (line_buf.size() > start && $urandom_range(0, 3) == 0)
				line_buf[$urandom_range(start, line_buf.size() - 1)] = rand_non_hex();
			push_ws($urandom_range(0, 2));
			send_line_buf();
			send_eoi();
		end else begin
			push_hex(HEX_CHARS);
			if (kind < 48) line_buf[$urandom_range(start, line_buf.size() - 1)] = rand_non_hex();
			push_ws($urandom_range(0, 3));
			case ($urandom_range(0, 5))
				0: begin
					line_buf.push_back(rand_non_hex() == CH_HASH ? 8'h7A : rand_non_hex());
					push_junk();
				end
				1: begin
					line_buf.push_back(CH_HASH);
					push_junk();
				end
				2: begin
					line_buf.push_back(CH_CR);
					push_junk();
				end
				3: begin
					line_buf.push_back(CH_NUL);
					push_junk();
				end
				default: ;
			endcase
			line_buf.push_back(CH_LF);
		end
		send_line_buf();
	endtask

	task automatic test_random_stream();
		int goal, lines;
		goal  = bytes_sent + RANDOM_BYTES;
		lines = 0;
		while (bytes_sent < goal) begin
			send_random_line();
			lines++;
			if (lines % 30 == 0) wait_drained();
		end
		send_eoi();
	endtask

	initial begin
		arst_n                = 1'b0;
		chars_if.valid        = 1'b0;
		chars_if.char_code    = 8'd0;
		chars_if.end_of_input = 1'b0;
		res_if.ready          = 1'b0;
		foreach (seen_by_status[i]) seen_by_status[i] = 0;
		clear_parser();
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		test_good_lines();
		test_ignored_lines();
		test_short_lines();
		test_trailing_garbage();
		test_bad_digits();
		test_end_of_input();
		test_random_stream();

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (pending_outcomes.size() != 0)
			report_mismatch("outcomes never delivered", 64'd0, 64'(pending_outcomes.size()));

		$display("summary: %0d bytes sent in %0d cycles, %0d mismatches", bytes_sent, cycles,
			mismatches);
		$display("summary: ok %0d, too short %0d, garbage %0d, bad digit %0d, eoi %0d",
			seen_by_status[ST_OK], seen_by_status[ST_SHORT], seen_by_status[ST_GARBAGE],
			seen_by_status[ST_BADHEX], seen_by_status[ST_EOI]);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
